// ----- hw/rtl/escaped_fixed_length_deframer_defines.svh -----
// assertion macros for the escaped fixed length deframer
`ifndef ESCAPED_FIXED_LENGTH_DEFRAMER_DEFINES_SVH
`define ESCAPED_FIXED_LENGTH_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EFLD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/efld_pkg.sv -----
// shared constants and types for the escaped fixed length deframer
package efld_pkg;

    localparam int ByteW               = 8;
    localparam int IndexW              = 6;
    localparam int MessageBytesDefault = 16;

    localparam logic [ByteW-1:0] FlagByte = 8'h7E;
    localparam logic [ByteW-1:0] EscByte  = 8'h7D;
    localparam logic [ByteW-1:0] EscXor   = 8'h20;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_COLLECT,
        ST_ESCAPE,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/efld_ifs.sv -----
// stream interfaces for received bytes and decoded message bytes
interface efld_rx_if;
    logic                      valid;
    logic                      ready;
    logic [efld_pkg::ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efld_msg_if;
    logic                       valid;
    logic                       ready;
    logic [efld_pkg::ByteW-1:0]  msg_byte;
    logic [efld_pkg::IndexW-1:0] msg_index;
    logic                       msg_last;

    modport source (output valid, output msg_byte, output msg_index, output msg_last,
                    input ready);
    modport sink (input valid, input msg_byte, input msg_index, input msg_last,
                  output ready);
endinterface

// ----- hw/rtl/escaped_fixed_length_deframer.sv -----
// top level: flag hunt, escape decode, message chain and output burst
//
//  channel | dir | payload                          | transfer
//  rx      | in  | rx_byte                          | valid && ready
//  msg     | out | msg_byte, msg_index, msg_last    | valid && ready
//
// a received byte is taken whenever valid is high outside a burst; ready is low only during a burst
// a completed message drains from the head of the cell chain, one byte per
// cycle while msg is taken
// a stall on msg holds the chain and the output register
// reset clears control state only; the chain needs no clearing since every
// cell is rewritten before a message drains
`include "escaped_fixed_length_deframer_defines.svh"

module escaped_fixed_length_deframer #(
    parameter int MESSAGE_BYTES = efld_pkg::MessageBytesDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    efld_rx_if.sink         rx,
    efld_msg_if.source      msg
);

    localparam int CntW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
    localparam logic [CntW-1:0] LastIdx = CntW'(MESSAGE_BYTES - 1);

    efld_pkg::state_t state_reg, state_next;
    logic [CntW-1:0]  fill_reg, fill_next;
    logic [CntW-1:0]  emit_reg, emit_next;
    logic             out_valid_reg;
    logic [efld_pkg::ByteW-1:0]  out_byte_reg;
    logic [efld_pkg::IndexW-1:0] out_index_reg;
    logic             out_last_reg;

    logic                       accept;
    logic                       store;
    logic                       load;
    logic [efld_pkg::ByteW-1:0] store_byte;
    logic [efld_pkg::ByteW-1:0] cell_q [MESSAGE_BYTES];

    assign rx.ready = (state_reg != efld_pkg::ST_EMIT);
    assign accept   = rx.valid && rx.ready;
    assign load     = (state_reg == efld_pkg::ST_EMIT) && (!out_valid_reg || msg.ready);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        emit_next  = emit_reg;
        store      = 1'b0;
        store_byte = rx.rx_byte;
        unique case (state_reg)
            efld_pkg::ST_WAIT:
            begin
                if (accept && rx.rx_byte == efld_pkg::FlagByte)
                begin
                    state_next = efld_pkg::ST_COLLECT;
                end
            end
            efld_pkg::ST_COLLECT:
            begin
                if (accept)
                begin
                    priority if (rx.rx_byte == efld_pkg::FlagByte)
                    begin
                        // abandon the partial message
                        fill_next  = '0;
                        state_next = efld_pkg::ST_WAIT;
                    end
                    else if (rx.rx_byte == efld_pkg::EscByte)
                    begin
                        state_next = efld_pkg::ST_ESCAPE;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
            end
            efld_pkg::ST_ESCAPE:
            begin
                if (accept)
                begin
                    store      = 1'b1;
                    store_byte = rx.rx_byte ^ efld_pkg::EscXor;
                    state_next = efld_pkg::ST_COLLECT;
                end
            end
            efld_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    if (emit_reg == LastIdx)
                    begin
                        emit_next  = '0;
                        state_next = efld_pkg::ST_WAIT;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = efld_pkg::ST_WAIT;
            end
        endcase
        if (store)
        begin
            if (fill_reg == LastIdx)
            begin
                fill_next  = '0;
                state_next = efld_pkg::ST_EMIT;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efld_pkg::ST_WAIT;
            fill_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            emit_reg  <= emit_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (msg.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= cell_q[0];
            out_index_reg <= efld_pkg::IndexW'(emit_reg);
            out_last_reg  <= (emit_reg == LastIdx);
        end
    end

    // bytes enter at the tail and move toward cell 0, which feeds the output
    genvar gi;
    generate
        for (gi = 0; gi < MESSAGE_BYTES; gi++)
        begin : g_cell
            logic [efld_pkg::ByteW-1:0] d_in;
            if (gi == MESSAGE_BYTES - 1)
            begin : g_tail
                assign d_in = store_byte;
            end
            else
            begin : g_link
                assign d_in = cell_q[gi+1];
            end
            efld_cell u_cell (
                .clk   (clk),
                .shift (store || load),
                .d_in  (d_in),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign msg.valid     = out_valid_reg;
    assign msg.msg_byte  = out_byte_reg;
    assign msg.msg_index = out_index_reg;
    assign msg.msg_last  = out_last_reg;

    `EFLD_ASSERT_NOW(a_last_index, clk, rst_n, out_valid_reg && out_last_reg, out_index_reg == efld_pkg::IndexW'(LastIdx), "last byte carries wrong index")
    `EFLD_ASSERT_NEXT(a_burst_start, clk, rst_n, store && fill_reg == LastIdx, state_reg == efld_pkg::ST_EMIT && emit_reg == '0 && fill_reg == '0, "completed message did not start a burst")
    `EFLD_ASSERT_NEXT(a_burst_end, clk, rst_n, load && emit_reg == LastIdx, state_reg == efld_pkg::ST_WAIT && out_valid_reg && out_last_reg, "burst did not end after last byte")

endmodule

// ----- hw/rtl/efld_cell.sv -----
// one byte cell of the message shift chain
module efld_cell (
    input  logic                       clk,
    input  logic                       shift,
    input  logic [efld_pkg::ByteW-1:0] d_in,
    output logic [efld_pkg::ByteW-1:0] q
);

    logic [efld_pkg::ByteW-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

endmodule
